### sv/nscc_pkg.sv
// ----------------------------------------------------------------------------
// nscc_pkg
// Shared types, character codes and hex decoding for the NMEA sentence
// checksum checker.
// ----------------------------------------------------------------------------
package nscc_pkg;

    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_CR    = 8'h0D;  // carriage return
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'

    localparam int unsigned RESULT_W = 26;
    localparam int unsigned TDATA_W  = 32;

    // first member sits in the highest bits, so checksum_ok lands at bit 0
    typedef struct packed {
        logic       first_sentence;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic [7:0] sentence_length;
        logic       checksum_ok;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = 4'(c - 8'h30);
        end else if (c inside {[8'h41:8'h46]}) begin
            h.value = 4'(c - 8'h37);
        end else if (c inside {[8'h61:8'h66]}) begin
            h.value = 4'(c - 8'h57);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

### sv/nscc_verdict.sv
// ----------------------------------------------------------------------------
// nscc_verdict
// Evaluates a finished sentence: framing, hex digits and checksum compare.
// ----------------------------------------------------------------------------
module nscc_verdict (
    input  logic [7:0]       i_count,
    input  logic [7:0]       i_xor,
    input  logic [2:0][7:0]  i_recent,   // entry 0 is the newest byte
    input  logic             i_first,
    output nscc_pkg::t_result o_result
);
    import nscc_pkg::*;

    t_hex       hi;
    t_hex       lo;
    logic       hex_ok;
    logic       long_enough;
    logic [7:0] rcv;
    logic [7:0] calc;

    always_comb begin
        hi          = hex_decode(i_recent[1]);
        lo          = hex_decode(i_recent[0]);
        hex_ok      = hi.valid && lo.valid;
        rcv         = hex_ok ? {hi.value, lo.value} : 8'd0;
        long_enough = (i_count >= 8'd4);
        // strip the star and the two digits back out of the running XOR
        calc        = long_enough ? (i_xor ^ i_recent[0] ^ i_recent[1] ^ i_recent[2]) : 8'd0;

        o_result.checksum_ok     = long_enough && (i_recent[2] == CH_STAR) && hex_ok
                                   && (rcv == calc);
        o_result.sentence_length = i_count;
        o_result.computed_sum    = calc;
        o_result.received_sum    = rcv;
        o_result.first_sentence  = i_first;
    end

endmodule

### sv/nmea_sentence_checksum_check_top.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_check_top
// NMEA 0183 sentence framing and checksum checker on a byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction, at up to one byte every cycle.
// Bytes are dropped until '$'; the sentence then runs until a carriage return
// (not counted) or until MAX_LEN bytes including the '$'. The byte that ends a
// sentence produces one verdict on m_tdata, registered in the cycle after that
// byte is taken; all other bytes produce nothing. The output register decouples
// the two sides, so input is stalled only while a verdict waits and m_tready
// is low.
module nmea_sentence_checksum_check_top #(
    parameter int unsigned MAX_LEN = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [nscc_pkg::TDATA_W-1:0] m_tdata
    // [0] checksum_ok, [8:1] sentence_length, [16:9] computed_sum,
    // [24:17] received_sum, [25] first_sentence, [31:26] zero
);
    import nscc_pkg::*;

    localparam logic [7:0] MAX_COUNT = 8'(MAX_LEN);

    logic             r_collecting;
    logic [7:0]       r_count;
    logic [7:0]       r_xor;
    logic [2:0][7:0]  r_recent;
    logic             r_seen;
    logic             r_out_valid;
    t_result          r_out;

    logic             n_collecting;
    logic [7:0]       n_count;
    logic [7:0]       n_xor;
    logic [2:0][7:0]  n_recent;
    logic             accept;
    logic             is_cr;
    logic             finish;
    t_result          verdict;

    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_cr    = (s_tdata == CH_CR);

    always_comb begin
        n_collecting = r_collecting;
        n_count      = r_count;
        n_xor        = r_xor;
        n_recent     = r_recent;
        finish       = 1'b0;
        if (!r_collecting) begin
            if (s_tdata == CH_START) begin
                n_collecting = 1'b1;
                n_count      = 8'd1;
                n_xor        = 8'd0;
                n_recent     = '0;
            end
        end else if (is_cr) begin
            finish = 1'b1;
        end else begin
            n_count  = r_count + 8'd1;
            n_xor    = r_xor ^ s_tdata;
            n_recent = {r_recent[1], r_recent[0], s_tdata};
            finish   = (n_count >= MAX_COUNT);
        end
        if (finish) begin
            n_collecting = 1'b0;
        end
    end

    // verdict sees the state after this byte (unchanged on carriage return)
    nscc_verdict u_verdict (
        .i_count  (n_count),
        .i_xor    (n_xor),
        .i_recent (n_recent),
        .i_first  (!r_seen),
        .o_result (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_count      <= 8'd0;
            r_xor        <= 8'd0;
            r_recent     <= '0;
            r_seen       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_collecting <= n_collecting;
                r_count      <= n_count;
                r_xor        <= n_xor;
                r_recent     <= n_recent;
                if (finish) begin
                    r_seen <= 1'b1;
                end
            end
            if (accept && finish) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && finish) begin
            r_out <= verdict;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(TDATA_W - RESULT_W)'(0), r_out};

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> (r_count >= 8'd1) && (r_count < MAX_COUNT))
        else $error("byte count out of range while collecting");

    a_cr_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_collecting && is_cr) |=> m_tvalid && !r_collecting)
        else $error("carriage return did not close the sentence");

    a_ok_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_out.checksum_ok) |-> (r_out.sentence_length >= 8'd4))
        else $error("passing verdict on a short sentence");

    a_first_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && finish && r_seen) |=> !r_out.first_sentence)
        else $error("first_sentence set after a sentence was already seen");
`endif

endmodule

### verif/nmea_sentence_checksum_check_top_tb.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_check_top_tb
// Self-checking bench for the NMEA sentence checksum checker. A byte stream of
// directed corner sentences and random good, corrupted, short, unterminated
// and full-length sentences with idle noise is pushed through the slave port
// in random bursts. Every accepted byte feeds a local sentence tracker that
// predicts each verdict, and every verdict taken from the master port is
// compared field by field. The receiver stalls on its own pattern and holds
// off once for a long stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_check_top_tb;

    import nscc_pkg::*;

    localparam int unsigned MAX_LEN     = 128;
    localparam int unsigned ITEMS       = 1650;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_START  = 1500;
    localparam int unsigned HOLD_LEN    = 400;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;    // [7:0] rx_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    // [0] checksum_ok, [8:1] sentence_length, [16:9] computed_sum,
    // [24:17] received_sum, [25] first_sentence, [31:26] zero

    logic [7:0] rx_bytes_q [$];
    t_result    verdict_q  [$];
    int         mismatch_cnt = 0;

    // sentence tracker state
    bit         sentence_open = 1'b0;
    logic [7:0] byte_cnt      = 8'h00;
    logic [7:0] xor_acc       = 8'h00;
    logic [7:0] tail [3]      = '{8'h00, 8'h00, 8'h00};   // [0] newest
    bit         sentence_seen = 1'b0;

    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned stretch_left = 0;
    int unsigned pat_cnt      = 0;
    t_rx_mode    rx_mode      = RX_FREE;
    int unsigned hold_cnt     = 0;
    bit          hold_off     = 1'b0;
    int unsigned cycle_cnt    = 0;

    nmea_sentence_checksum_check_top #(
        .MAX_LEN(MAX_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // advance the tracker by one accepted byte; queue a verdict when a sentence ends
    task automatic track_byte(input logic [7:0] b);
        t_result    v;
        logic [3:0] hi;
        logic [3:0] lo;
        bit         hi_ok;
        bit         lo_ok;
        if (!sentence_open) begin
            if (b == CH_START) begin
                sentence_open = 1'b1;
                byte_cnt      = 8'd1;
                xor_acc       = 8'h00;
                tail          = '{8'h00, 8'h00, 8'h00};
            end
            return;
        end
        if (b != CH_CR) begin
            byte_cnt = byte_cnt + 8'd1;
            xor_acc  = xor_acc ^ b;
            tail[2]  = tail[1];
            tail[1]  = tail[0];
            tail[0]  = b;
            if (byte_cnt < MAX_LEN) begin
                return;
            end
        end
        hi_ok = hex_digit(tail[1], hi);
        lo_ok = hex_digit(tail[0], lo);
        v.received_sum    = (hi_ok && lo_ok) ? {hi, lo} : 8'h00;
        // the star and both digits were folded in, so xor them back out
        v.computed_sum    = (byte_cnt >= 8'd4) ? (xor_acc ^ tail[0] ^ tail[1] ^ tail[2]) : 8'h00;
        v.checksum_ok     = (byte_cnt >= 8'd4) && (tail[2] == CH_STAR) && hi_ok && lo_ok
                            && (v.received_sum == v.computed_sum);
        v.sentence_length = byte_cnt;
        v.first_sentence  = !sentence_seen;
        sentence_seen     = 1'b1;
        sentence_open     = 1'b0;
        verdict_q.push_back(v);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic gen_sentence();
        int unsigned kind;
        int unsigned plen;
        logic [7:0]  acc;
        logic [7:0]  b;
        logic [7:0]  d [2];
        logic [3:0]  nib;
        kind = $urandom_range(0, 99);
        acc  = 8'h00;
        if (kind < 3) begin
            plen = $urandom_range(100, 140);    // around and past MAX_LEN
        end else if (kind < 10) begin
            plen = $urandom_range(0, 2);
        end else begin
            plen = $urandom_range(0, 20);
        end
        rx_bytes_q.push_back(CH_START);
        for (int i = 0; i < plen; i++) begin
            b = 8'($urandom);
            if (b == CH_CR) begin
                b = 8'h8D;
            end
            if (kind >= 95 && $urandom_range(0, 3) == 0) begin
                b = CH_START;
            end
            rx_bytes_q.push_back(b);
            acc ^= b;
        end
        if (kind >= 10) begin
            b = CH_STAR;
            if (kind >= 80 && kind < 90) begin
                do b = 8'($urandom); while (b == CH_STAR || b == CH_CR);
            end
            rx_bytes_q.push_back(b);
            if (kind >= 60 && kind < 70) begin
                acc ^= 8'($urandom_range(1, 255));
            end
            d[0] = hex_char(acc[7:4], $urandom_range(0, 1));
            d[1] = hex_char(acc[3:0], $urandom_range(0, 1));
            if (kind >= 70 && kind < 80) begin
                do b = 8'($urandom); while (hex_digit(b, nib) || b == CH_CR);
                d[$urandom_range(0, 1)] = b;
            end
            rx_bytes_q.push_back(d[0]);
            rx_bytes_q.push_back(d[1]);
        end
        // a few sentences run on into the next one
        if (kind < 90 || kind >= 95) begin
            rx_bytes_q.push_back(CH_CR);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) rx_bytes_q.push_back(8'($urandom));
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (rx_bytes_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_bytes_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stretches of free flow, random stalls and sparse acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 2));
                stretch_left = $urandom_range(20, 200);
            end else begin
                stretch_left--;
            end
            pat_cnt++;
            case (rx_mode)
                RX_FREE:   m_tready <= !hold_off;
                RX_RANDOM: m_tready <= !hold_off && ($urandom_range(0, 1) == 1);
                default:   m_tready <= !hold_off && (pat_cnt % 4 == 0);
            endcase
        end
    end

    // one long hold-off on the result side to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
            hold_off <= 1'b0;
        end else begin
            hold_cnt <= hold_cnt + 1;
            hold_off <= (hold_cnt >= HOLD_START) && (hold_cnt < HOLD_START + HOLD_LEN);
        end
    end

    // monitor: check each result transaction, then track each input transaction
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_W-1:0];
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, got %0h", $time, m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
                    check_field("sentence_length", want.sentence_length, got.sentence_length);
                    check_field("computed_sum", want.computed_sum, got.computed_sum);
                    check_field("received_sum", want.received_sum, got.received_sum);
                    check_field("first_sentence", 8'(want.first_sentence),
                                8'(got.first_sentence));
                    check_field("padding", 8'h00, 8'(m_tdata[TDATA_W-1:RESULT_W]));
                end
            end
            if (s_tvalid && s_tready) begin
                track_byte(s_tdata);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("nmea_sentence_checksum_check_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [7:0] directed [];
        // idle noise, bare dollar, short, zero byte, dollar as data, lowercase digits
        directed = '{
            8'hFF, 8'h00,
            CH_START, CH_CR,
            CH_START, 8'h41, CH_CR,
            CH_START, 8'h00, CH_STAR, 8'h30, 8'h30, CH_CR,
            CH_START, CH_START, CH_STAR, 8'h32, 8'h34, CH_CR,
            CH_START, 8'hFF, CH_STAR, 8'h66, 8'h66, CH_CR
        };
        foreach (directed[i]) begin
            rx_bytes_q.push_back(directed[i]);
        end
        while (rx_bytes_q.size() < ITEMS) begin
            gen_sentence();
        end
        rx_bytes_q.push_back(CH_CR);    // close whatever is still open

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_bytes_q.size() != 0 || s_tvalid) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("nmea_sentence_checksum_check_top_tb: done, clean");
        end else begin
            $display("nmea_sentence_checksum_check_top_tb: done, errors");
        end
        $finish;
    end

endmodule
